// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and helpers of the pressure compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int unsigned DivW = 32;
    localparam int unsigned UpW  = 19;

    // configuration register indexes
    localparam logic [2:0] RegPairA = 3'd0;
    localparam logic [2:0] RegPairB = 3'd1;
    localparam logic [2:0] RegPairC = 3'd2;
    localparam logic [2:0] RegPairD = 3'd3;
    localparam logic [2:0] RegPairE = 3'd4;
    localparam logic [2:0] RegOss   = 3'd5;

    localparam logic [31:0] TempBias   = 32'd4000;
    localparam logic [31:0] HalfScale  = 32'd32768;
    localparam logic [31:0] PressK1    = 32'd3038;
    localparam logic [31:0] PressK2    = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] PressK3    = 32'd3791;
    localparam logic [1:0]  OssReset   = 2'd3;

    // calibration coefficients, extended to 32 bits
    typedef struct packed {
        logic [31:0] ac1;
        logic [31:0] ac2;
        logic [31:0] ac3;
        logic [31:0] ac4;
        logic [31:0] ac5;
        logic [31:0] ac6;
        logic [31:0] b1;
        logic [31:0] b2;
        logic [31:0] mc;
        logic [31:0] md;
        logic [1:0]  oss;
    } t_cal;

    // sideband that rides through a divider
    typedef struct packed {
        logic            fault;
        logic            flag;
        logic [31:0]     word;
        logic [UpW-1:0]  up;
    } t_ctx;

    function automatic logic [31:0] sext16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // signed divide by four, truncating toward zero
    function automatic logic [31:0] sdiv4(logic [31:0] v);
        logic [31:0] t;
        t = v + (v[31] ? 32'd3 : 32'd0);
        return 32'($signed(t) >>> 2);
    endfunction

    function automatic logic [15:0] oss_scale(logic [1:0] oss);
        logic [15:0] s;
        case (oss)
            2'd0:    s = 16'd50000;
            2'd1:    s = 16'd25000;
            2'd2:    s = 16'd12500;
            default: s = 16'd6250;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/bpc_udiv.sv =====
// ----------------------------------------------------------------------------
// bpc_udiv
// Unsigned 32/32 divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module bpc_udiv
    import bpc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  logic [DivW-1:0] i_num,
    input  logic [DivW-1:0] i_den,
    input  t_ctx            i_ctx,
    output logic            o_valid,
    output logic [DivW-1:0] o_quo,
    output t_ctx            o_ctx
);

    logic [DivW-1:0] r_rem [DivW+1];
    logic [DivW-1:0] r_num [DivW+1];
    logic [DivW-1:0] r_dvs [DivW+1];
    t_ctx            r_ctx [DivW+1];
    logic [DivW:0]   r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_adv) begin
            r_vld[0] <= i_valid;
        end
        if (i_adv) begin
            r_rem[0] <= '0;
            r_num[0] <= i_num;
            r_dvs[0] <= i_den;
            r_ctx[0] <= i_ctx;
        end
    end

    for (genvar k = 0; k < DivW; k++) begin : g_stage
        logic [DivW:0]   w_trial;
        logic [DivW:0]   w_diff;
        logic            w_ge;
        assign w_trial = {r_rem[k], r_num[k][DivW-1]};
        assign w_diff  = w_trial - {1'b0, r_dvs[k]};
        assign w_ge    = !w_diff[DivW];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (i_adv) begin
                r_rem[k+1] <= w_ge ? w_diff[DivW-1:0] : w_trial[DivW-1:0];
                r_num[k+1] <= {r_num[k][DivW-2:0], w_ge};
                r_dvs[k+1] <= r_dvs[k];
                r_ctx[k+1] <= r_ctx[k];
            end
        end
    end

    assign o_valid = r_vld[DivW];
    assign o_quo   = r_num[DivW];
    assign o_ctx   = r_ctx[DivW];

endmodule

// ===== rtl/bpc_coef.sv =====
// ----------------------------------------------------------------------------
// bpc_coef
// Temperature finish and pressure coefficient stages between the dividers.
// ----------------------------------------------------------------------------
module bpc_coef
    import bpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  t_cal        i_cal,
    input  logic        i_valid,
    input  logic [31:0] i_quo,
    input  t_ctx        i_ctx,
    output logic        o_valid,
    output logic [31:0] o_num,
    output logic [31:0] o_den,
    output t_ctx        o_ctx
);

    logic [9:0]     r_v;
    logic [9:0]     r_f;
    logic [31:0]    r_b5 [10];
    logic [UpW-1:0] r_up [10];
    logic [31:0] r_b6;
    logic [31:0] r_psq, r_pa2, r_pa3;
    logic [31:0] r_sq, r_xa, r_xc;
    logic [31:0] r_pb2, r_pb1, r_xa5, r_xc5;
    logic [31:0] r_s3, r_s4;
    logic [31:0] r_t, r_x3b;
    logic [31:0] r_b3, r_b4in;
    logic [31:0] r_b4p, r_b7d;
    logic [31:0] r_b4, r_b7;
    logic [31:0] w_x2;

    assign w_x2 = i_ctx.flag ? (32'd0 - i_quo) : i_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[8:0], i_valid};
        end
        if (i_adv) begin
            r_f[0]  <= i_ctx.fault;
            r_b5[0] <= i_ctx.word + w_x2;
            r_up[0] <= i_ctx.up;
            for (int k = 1; k < 10; k++) begin
                r_f[k]  <= r_f[k-1];
                r_b5[k] <= r_b5[k-1];
                r_up[k] <= r_up[k-1];
            end
            // b6
            r_b6   <= r_b5[0] - TempBias;
            // products on b6
            r_psq  <= r_b6 * r_b6;
            r_pa2  <= i_cal.ac2 * r_b6;
            r_pa3  <= i_cal.ac3 * r_b6;
            r_sq   <= 32'($signed(r_psq) >>> 12);
            r_xa   <= 32'($signed(r_pa2) >>> 11);
            r_xc   <= 32'($signed(r_pa3) >>> 13);
            r_pb2  <= i_cal.b2 * r_sq;
            r_pb1  <= i_cal.b1 * r_sq;
            r_xa5  <= r_xa;
            r_xc5  <= r_xc;
            r_s3   <= (i_cal.ac1 << 2) + 32'($signed(r_pb2) >>> 11) + r_xa5;
            r_s4   <= r_xc5 + 32'($signed(r_pb1) >>> 16) + 32'd2;
            r_t    <= (r_s3 << i_cal.oss) + 32'd2;
            r_x3b  <= sdiv4(r_s4);
            r_b3   <= sdiv4(r_t);
            r_b4in <= r_x3b + HalfScale;
            r_b4p  <= i_cal.ac4 * r_b4in;
            r_b7d  <= {{(32-UpW){1'b0}}, r_up[7]} - r_b3;
            r_b4   <= r_b4p >> 15;
            r_b7   <= r_b7d * {16'd0, oss_scale(i_cal.oss)};
        end
    end

    logic w_pos;
    assign w_pos = (r_b7 != 32'd0) && !r_b7[31];

    // last stage register is the divider's input stage
    assign o_valid    = r_v[9];
    assign o_num      = w_pos ? {r_b7[30:0], 1'b0} : r_b7;
    assign o_den      = r_b4;
    assign o_ctx.fault = r_f[9] || (r_b4 == 32'd0);
    assign o_ctx.flag  = w_pos;
    assign o_ctx.word  = r_b5[9];
    assign o_ctx.up    = r_up[9];

endmodule

// ===== rtl/barometric_pressure_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_unit
// Integer temperature and pressure compensation of raw barometric readings.
// ----------------------------------------------------------------------------
// One raw temperature and raw pressure pair enters per cycle while the
// pipeline advances and leaves, compensated, after 84 register stages in
// all: the two bit-per-stage 32-bit dividers (temperature correction and
// final pressure quotient), 33 stages each, plus 18 stages of multiply
// and shift work. The whole pipeline advances together: when the output
// holds an item and the sink stalls, every stage holds and the input is
// stalled too. Calibration and oversampling registers are read live by all
// stages, so write them only while no item is in flight. A zero divisor
// gives zero results with the fault flag set.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_unit
    import bpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_raw_temperature,
    input  logic [18:0] i_raw_pressure,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_temperature_tenths,
    output logic [31:0] o_pressure_pa,
    output logic        o_divide_fault,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_pair [5];
    logic [1:0]  r_oss;
    t_cal        w_cal;
    logic        w_adv;

    // configuration: always ready, ignore indexes past the list
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) r_pair[k] <= '0;
            r_oss <= OssReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegPairA: r_pair[0] <= i_cfg_data;
                RegPairB: r_pair[1] <= i_cfg_data;
                RegPairC: r_pair[2] <= i_cfg_data;
                RegPairD: r_pair[3] <= i_cfg_data;
                RegPairE: r_pair[4] <= i_cfg_data;
                RegOss:   r_oss     <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_cal.ac1 = sext16(r_pair[0][31:16]);
    assign w_cal.ac2 = sext16(r_pair[0][15:0]);
    assign w_cal.ac3 = sext16(r_pair[1][31:16]);
    assign w_cal.ac4 = {16'd0, r_pair[1][15:0]};
    assign w_cal.ac5 = {16'd0, r_pair[2][31:16]};
    assign w_cal.ac6 = {16'd0, r_pair[2][15:0]};
    assign w_cal.b1  = sext16(r_pair[3][31:16]);
    assign w_cal.b2  = sext16(r_pair[3][15:0]);
    assign w_cal.mc  = sext16(r_pair[4][31:16]);
    assign w_cal.md  = sext16(r_pair[4][15:0]);
    assign w_cal.oss = r_oss;

    // advance everything unless a finished item is held by the sink
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // front: raw temperature linear term and divider operands
    logic [2:0]     r_fv;
    logic [31:0]    r_d1, r_m2, r_x1, r_den;
    logic [UpW-1:0] r_up1, r_up2, r_up3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (w_adv) begin
            r_fv <= {r_fv[1:0], i_valid};
        end
        if (w_adv) begin
            r_d1  <= {16'd0, i_raw_temperature} - w_cal.ac6;
            r_up1 <= i_raw_pressure;
            r_m2  <= r_d1 * w_cal.ac5;
            r_up2 <= r_up1;
            r_x1  <= 32'($signed(r_m2) >>> 15);
            r_den <= 32'($signed(r_m2) >>> 15) + w_cal.md;
            r_up3 <= r_up2;
        end
    end

    // signed quotient through magnitudes; mc * 2048
    logic [31:0] w_tnum, w_anum, w_aden;
    t_ctx        w_ctx1;
    assign w_tnum       = w_cal.mc << 11;
    assign w_anum       = w_tnum[31] ? (32'd0 - w_tnum) : w_tnum;
    assign w_aden       = r_den[31] ? (32'd0 - r_den) : r_den;
    assign w_ctx1.fault = (r_den == 32'd0);
    assign w_ctx1.flag  = w_tnum[31] ^ r_den[31];
    assign w_ctx1.word  = r_x1;
    assign w_ctx1.up    = r_up3;

    logic        w_v1;
    logic [31:0] w_q1;
    t_ctx        w_c1;

    bpc_udiv u_div_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_fv[2]),
        .i_num   (w_anum),
        .i_den   (w_aden),
        .i_ctx   (w_ctx1),
        .o_valid (w_v1),
        .o_quo   (w_q1),
        .o_ctx   (w_c1)
    );

    logic        w_v2;
    logic [31:0] w_num2, w_den2;
    t_ctx        w_c2;

    bpc_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cal   (w_cal),
        .i_valid (w_v1),
        .i_quo   (w_q1),
        .i_ctx   (w_c1),
        .o_valid (w_v2),
        .o_num   (w_num2),
        .o_den   (w_den2),
        .o_ctx   (w_c2)
    );

    logic        w_v3;
    logic [31:0] w_q3;
    t_ctx        w_c3;

    bpc_udiv u_div_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_v2),
        .i_num   (w_num2),
        .i_den   (w_den2),
        .i_ctx   (w_c2),
        .o_valid (w_v3),
        .o_quo   (w_q3),
        .o_ctx   (w_c3)
    );

    // back: second-order pressure correction
    logic [4:0]  r_pv;
    logic [3:0]  r_pf;
    logic [31:0] r_pb5 [4];
    logic [31:0] r_p1, r_p2, r_p3, r_p4;
    logic [31:0] r_sq2, r_m22, r_x13, r_x23, r_sum4;
    logic [31:0] r_out_p;
    logic [15:0] r_out_t;
    logic        r_out_f;
    logic [31:0] w_s8, w_tsum;

    assign w_s8   = 32'($signed(r_p1) >>> 8);
    assign w_tsum = r_pb5[3] + 32'd8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (w_adv) begin
            r_pv <= {r_pv[3:0], w_v3};
        end
        if (w_adv) begin
            r_pf[0]  <= w_c3.fault;
            r_pb5[0] <= w_c3.word;
            for (int k = 1; k < 4; k++) begin
                r_pf[k]  <= r_pf[k-1];
                r_pb5[k] <= r_pb5[k-1];
            end
            r_p1   <= w_c3.flag ? w_q3 : {w_q3[30:0], 1'b0};
            r_sq2  <= w_s8 * w_s8;
            r_m22  <= PressK2 * r_p1;
            r_p2   <= r_p1;
            r_x13  <= r_sq2 * PressK1;
            r_x23  <= 32'($signed(r_m22) >>> 16);
            r_p3   <= r_p2;
            r_sum4 <= 32'($signed(r_x13) >>> 16) + r_x23 + PressK3;
            r_p4   <= r_p3;
            // output register; zero results on a divide fault
            r_out_f <= r_pf[3];
            r_out_p <= r_pf[3] ? 32'd0 : r_p4 + 32'($signed(r_sum4) >>> 4);
            r_out_t <= r_pf[3] ? 16'd0 : w_tsum[19:4];
        end
    end

    assign o_valid              = r_pv[4];
    assign o_temperature_tenths = r_out_t;
    assign o_pressure_pa        = r_out_p;
    assign o_divide_fault       = r_out_f;

endmodule

// ===== tb/tb_barometric_pressure_compensation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barometric_pressure_compensation_unit
// Feeds raw temperature and pressure pairs through the compensation pipeline
// under several calibration sets. It predicts each reading in a scoreboard
// and checks the results in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_barometric_pressure_compensation_unit;
    import bpc_pkg::*;

    localparam int CycleLimit = 400000;

    typedef struct {
        logic [15:0] temp;
        logic [31:0] press;
        logic        fault;
    } t_reading;

    // Scoreboard: holds its own copy of the calibration and the readings
    // still owed by the pipeline, oldest first.
    class compensation_scoreboard;
        logic [31:0] pair [5];
        logic [1:0]  oss;
        t_reading    owed [$];
        int          errors;

        function new();
            foreach (pair[i]) pair[i] = '0;
            oss    = 2'd3;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            if (idx < RegOss) pair[idx] = data;
            else if (idx == RegOss) oss = data[1:0];
        endfunction

        function logic [31:0] asr(logic [31:0] v, int s);
            return $signed(v) >>> s;
        endfunction

        function logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
            longint q;
            q = longint'($signed(a)) / longint'($signed(b));
            return q[31:0];
        endfunction

        function logic [31:0] sx(logic [15:0] v);
            return {{16{v[15]}}, v};
        endfunction

        function t_reading compensate(logic [15:0] ut, logic [18:0] up);
            t_reading r;
            logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
            logic [31:0] x1, x2, x3, b5, b6, b3, b4, b7, p, den, sq, t;
            ac1 = sx(pair[0][31:16]);  ac2 = sx(pair[0][15:0]);
            ac3 = sx(pair[1][31:16]);  ac4 = {16'd0, pair[1][15:0]};
            ac5 = {16'd0, pair[2][31:16]};  ac6 = {16'd0, pair[2][15:0]};
            b1  = sx(pair[3][31:16]);  b2  = sx(pair[3][15:0]);
            mc  = sx(pair[4][31:16]);  md  = sx(pair[4][15:0]);
            r = '{temp: 16'd0, press: 32'd0, fault: 1'b1};
            t   = ({16'd0, ut} - ac6) * ac5;
            x1  = asr(t, 15);
            den = x1 + md;
            if (den == 0) return r;
            t  = mc * 32'd2048;
            x2 = sdiv(t, den);
            b5 = x1 + x2;
            b6 = b5 - 32'd4000;
            t  = b6 * b6;
            sq = asr(t, 12);
            t  = b2 * sq;
            x1 = asr(t, 11);
            t  = ac2 * b6;
            x2 = asr(t, 11);
            x3 = x1 + x2;
            t  = ac1 * 32'd4 + x3;
            t  = t << oss;
            b3 = sdiv(t + 32'd2, 32'd4);
            t  = ac3 * b6;
            x1 = asr(t, 13);
            t  = b1 * sq;
            x2 = asr(t, 16);
            x3 = sdiv(x1 + x2 + 32'd2, 32'd4);
            t  = ac4 * (x3 + 32'd32768);
            b4 = t >> 15;
            if (b4 == 0) return r;
            t  = {13'd0, up} - b3;
            b7 = t * (32'd50000 >> oss);
            if (b7 != 0 && !b7[31]) begin
                t = b7 * 32'd2;
                p = t / b4;
            end else begin
                t = b7 / b4;
                p = t * 32'd2;
            end
            x1 = asr(p, 8) * asr(p, 8);
            t  = x1 * 32'd3038;
            x1 = asr(t, 16);
            t  = 32'hFFFF_E343 * p;
            x2 = asr(t, 16);
            p  = p + asr(x1 + x2 + 32'd3791, 4);
            t  = asr(b5 + 32'd8, 4);
            r  = '{temp: t[15:0], press: p, fault: 1'b0};
            return r;
        endfunction

        function void note_sample(logic [15:0] ut, logic [18:0] up);
            owed.push_back(compensate(ut, up));
        endfunction

        function void check_reading(logic [15:0] temp, logic [31:0] press, logic fault);
            t_reading e;
            if (owed.size() == 0) begin
                $error("unexpected item: temp %0h press %0h fault %0b", temp, press, fault);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (temp !== e.temp) begin
                $error("temperature_tenths: expected %0h, got %0h", e.temp, temp);
                errors++;
            end
            if (press !== e.press) begin
                $error("pressure_pa: expected %0h, got %0h", e.press, press);
                errors++;
            end
            if (fault !== e.fault) begin
                $error("divide_fault: expected %0b, got %0b", e.fault, fault);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_raw_temperature = '0;
    logic [18:0] i_raw_pressure = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_temperature_tenths;
    logic [31:0] o_pressure_pa;
    logic        o_divide_fault;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    compensation_scoreboard sb = new();

    bit quiet;      // no idling on either side in the last stretch
    bit hold_req;   // ask the sink for one long hold-off
    int cycles;

    barometric_pressure_compensation_unit u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("tb_barometric_pressure_compensation_unit: errors");
            $finish;
        end
    end

    // Sink: check each accepted item, then pick the stall for the next cycle.
    // Stalls come in random bursts; one long hold-off fills the pipeline so
    // the input side has to stall as well.
    initial begin
        int burst;
        int hold_left;
        bit held;
        burst = 0;
        hold_left = 0;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                sb.check_reading(o_temperature_tenths, o_pressure_pa, o_divide_fault);
            if (hold_req && !held) begin
                held = 1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 9) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Offer one item and hold it until accepted; sometimes idle afterwards.
    task automatic send_sample(logic [15:0] ut, logic [18:0] up);
        i_valid           <= 1'b1;
        i_raw_temperature <= ut;
        i_raw_pressure    <= up;
        do @(posedge i_clk); while (o_stall);
        sb.note_sample(ut, up);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Wait until every owed item has come back, then let the pipeline settle.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.owed.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // Load a full calibration set; only call with the pipeline empty.
    task automatic load_cal(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [31:0] d, logic [31:0] e, logic [1:0] oss);
        cfg_write(RegPairA, a);
        cfg_write(RegPairB, b);
        cfg_write(RegPairC, c);
        cfg_write(RegPairD, d);
        cfg_write(RegPairE, e);
        cfg_write(RegOss, {30'd0, oss});
        i_cfg_valid <= 1'b0;
    endtask

    // Typical sensor calibration: ac1 408, ac2 -72, ac3 -14383, ac4 32741,
    // ac5 32757, ac6 23153, b1 6190, b2 4, mc -8711, md 2868.
    task automatic load_typical(logic [1:0] oss);
        load_cal(32'h0198_FFB8, 32'hC7D1_7FE5, 32'h7FF5_5A71,
                 32'h182E_0004, 32'hDDF9_0B34, oss);
    endtask

    // Typical calibration with every coefficient nudged at random.
    task automatic load_nudged(logic [1:0] oss);
        logic [15:0] h [10];
        h = '{16'h0198, 16'hFFB8, 16'hC7D1, 16'h7FE5, 16'h7FF5,
              16'h5A71, 16'h182E, 16'h0004, 16'hDDF9, 16'h0B34};
        foreach (h[i]) h[i] = h[i] + 16'($urandom_range(0, 511)) - 16'd256;
        load_cal({h[0], h[1]}, {h[2], h[3]}, {h[4], h[5]},
                 {h[6], h[7]}, {h[8], h[9]}, oss);
    endtask

    task automatic random_samples(int n);
        logic [15:0] ut;
        logic [18:0] up;
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
                ut = 16'($urandom);
                up = 19'($urandom);
            end else begin
                ut = 16'($urandom_range(20000, 36000));
                up = 19'($urandom_range(15000, 50000) << sb.oss);
            end
            send_sample(ut, up);
        end
    endtask

    initial begin
        quiet    = 0;
        hold_req = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: typical values and field extremes at both oversampling ends.
        load_typical(2'd0);
        send_sample(16'd27898, 19'd23843);
        send_sample(16'd0, 19'd0);
        send_sample(16'hFFFF, 19'h7FFFF);
        send_sample(16'd0, 19'h7FFFF);
        send_sample(16'hFFFF, 19'd0);
        send_sample(16'd23153, 19'd1000);
        drain();
        load_typical(2'd3);
        send_sample(16'd27898, 19'd190744);
        send_sample(16'd0, 19'd0);
        send_sample(16'hFFFF, 19'h7FFFF);
        send_sample(16'h5555, 19'h2AAAA);
        send_sample(16'hAAAA, 19'h55555);
        drain();
        // Zero temperature divisor: ac5 and md both zero.
        load_cal(32'h0198_FFB8, 32'hC7D1_7FE5, 32'h0000_5A71, 32'h182E_0004,
                 32'hDDF9_0000, 2'd1);
        send_sample(16'd27898, 19'd23843);
        send_sample(16'hFFFF, 19'h7FFFF);
        drain();
        // Zero pressure divisor: ac4 zero.
        load_cal(32'h0198_FFB8, 32'hC7D1_0000, 32'h7FF5_5A71, 32'h182E_0004,
                 32'hDDF9_0B34, 2'd2);
        send_sample(16'd27898, 19'd23843);
        send_sample(16'd0, 19'h7FFFF);
        drain();
        // All coefficients at their all-ones extreme.
        load_cal('1, '1, '1, '1, '1, 2'd0);
        send_sample(16'hFFFF, 19'h7FFFF);
        send_sample(16'd0, 19'd0);
        drain();

        // Random phases, one calibration set each.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       load_typical(2'($urandom));
                1:       load_cal('1, '1, '1, '1, '1, 2'd0);
                2, 3, 7: load_nudged(2'($urandom));
                default: load_cal($urandom, $urandom, $urandom, $urandom,
                                  $urandom, 2'($urandom));
            endcase
            if (ph == 3) hold_req = 1;
            if (ph == 7) quiet = 1;
            random_samples(180);
            drain();
        end

        repeat (90) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("tb_barometric_pressure_compensation_unit: clean");
        end else begin
            $display("tb_barometric_pressure_compensation_unit: errors");
        end
        $finish;
    end

endmodule
